[design/fixed_capacity_set_table_assert.svh]
// assertion macros for the fixed capacity set table
// no dependencies; taken in by the top level with `include
`ifndef FIXED_CAPACITY_SET_TABLE_ASSERT_SVH
`define FIXED_CAPACITY_SET_TABLE_ASSERT_SVH

// condition now implies consequence in the same cycle
`define FCST_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("fixed_capacity_set_table: check failed");

// condition now implies consequence in the next cycle
`define FCST_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("fixed_capacity_set_table: check failed");

`endif

[design/fcst_pkg.sv]
// shared types and codes for the fixed capacity set table
// no dependencies; imported by the controller, datapath and top level
package fcst_pkg;

   // result status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   // request modes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   // field widths of one beat
   localparam int ITEM_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 3;
   localparam int ENTRIES_W = 4;

   // commands from controller to datapath
   typedef struct packed {
      logic load;    // capture request beat
      logic find;    // compare all slots, register hit vectors
      logic commit;  // pick slot, update table, load result register
   } fcst_cmd_type;

endpackage

[design/fcst_ctrl.sv]
// controller state machine for the fixed capacity set table
// depends on fcst_pkg; drives datapath commands and both handshakes
module fcst_ctrl
   import fcst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output fcst_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_FIND   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // result register can take a new beat when empty or being drained
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            cmd.find = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/fcst_datapath.sv]
// slot store, compare array, priority pick and result register
// depends on fcst_pkg; steered by commands from fcst_ctrl
module fcst_datapath
   import fcst_pkg::*;
#(
   parameter int CAPACITY    = 8,
   parameter int VALUE_WIDTH = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  fcst_cmd_type         cmd,
   input  logic                 req_mode,
   input  logic [ITEM_W-1:0]    req_value,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]    rsp_slot_index,
   output logic [ENTRIES_W-1:0] rsp_entries_now
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   // table state
   logic [VALUE_WIDTH-1:0] slot_value_ff [CAPACITY];
   logic [CAPACITY-1:0]    slot_used_ff, slot_used_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   // captured request and hit vectors
   logic                   mode_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [CAPACITY-1:0]    free_vec_ff, match_vec_ff;

   // result register
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [ENTRIES_W-1:0]   entries_ff, entries_in;

   logic [63:0]            value_ext;
   logic [CAPACITY-1:0]    match_vec, pick_vec;
   logic [IDX_W-1:0]       pick_idx;
   logic                   pick_hit;
   logic                   done;
   logic [31:0]            idx_wide, cnt_wide;

   // sign extend the beat value, keep the stored width
   assign value_ext = {{(64 - ITEM_W){req_value[ITEM_W-1]}}, req_value};

   // compare every slot against the request
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_vec[i] = slot_used_ff[i] && (slot_value_ff[i] == value_ff);
      end
   end

   // lowest set bit of the chosen vector
   assign pick_vec = (mode_ff == MODE_INSERT) ? free_vec_ff : match_vec_ff;
   assign pick_hit = |pick_vec;
   always_comb begin
      pick_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (pick_vec[i]) begin
            pick_idx = IDX_W'(i);
         end
      end
   end

   // outcome and table update
   always_comb begin
      status_in    = ST_DONE;
      slot_used_in = slot_used_ff;
      count_in     = count_ff;
      if (mode_ff == MODE_INSERT) begin
         if ((count_ff >= CNT_FULL) || !pick_hit) begin
            status_in = ST_OVERFLOW;
         end
      end else begin
         if (count_ff == '0) begin
            status_in = ST_UNDERFLOW;
         end else if (!pick_hit) begin
            status_in = ST_NOT_FOUND;
         end
      end
      done = (status_in == ST_DONE);
      if (done) begin
         if (mode_ff == MODE_INSERT) begin
            slot_used_in[pick_idx] = 1'b1;
            count_in               = count_ff + CNT_W'(1);
         end else begin
            slot_used_in[pick_idx] = 1'b0;
            count_in               = count_ff - CNT_W'(1);
         end
      end
      idx_wide   = 32'(pick_idx);
      cnt_wide   = 32'(count_in);
      slot_in    = done ? idx_wide[SLOT_W-1:0] : '0;
      entries_in = cnt_wide[ENTRIES_W-1:0];
   end

   // control state: flags and count
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
         count_ff     <= '0;
      end else if (cmd.commit) begin
         slot_used_ff <= slot_used_in;
         count_ff     <= count_in;
      end
   end

   // slot value store, at most one write per commit, on a successful insert
   always_ff @(posedge clock) begin
      if (cmd.commit && done && (mode_ff == MODE_INSERT)) begin
         slot_value_ff[pick_idx] <= value_ff;
      end
   end

   // request capture and hit vectors
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         value_ff <= value_ext[VALUE_WIDTH-1:0];
      end
      if (cmd.find) begin
         free_vec_ff  <= ~slot_used_ff;
         match_vec_ff <= match_vec;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff  <= status_in;
         slot_ff    <= slot_in;
         entries_ff <= entries_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_slot_index  = slot_ff;
   assign rsp_entries_now = entries_ff;

endmodule

[design/fixed_capacity_set_table.sv]
// Fixed capacity set table: CAPACITY slots of VALUE_WIDTH-bit values with used
// flags and an entry count. Each request beat inserts a value into the lowest
// free slot or removes the lowest used slot holding a matching value, and
// returns exactly one result beat (status, slot index, entry count after the
// request). A request goes through capture, a compare of all slots in
// parallel into a registered hit vector, and a commit that picks the lowest
// hit with a priority encoder and updates the table; one request is in work
// at a time. The commit waits only while the previous result beat is still
// unclaimed in the output register. Flags and count clear on reset.
// depends on fcst_pkg, fcst_ctrl, fcst_datapath and the assertion macro header
`include "fixed_capacity_set_table_assert.svh"

module fixed_capacity_set_table
   import fcst_pkg::*;
#(
   parameter int CAPACITY    = 8,
   parameter int VALUE_WIDTH = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // mode[0], item_value[32:1], zero [39:33]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], slot_index[4:2],
                                    // entries_now[8:5], zero [15:9]
);

   localparam logic [ENTRIES_W-1:0] ENTRIES_FULL = ENTRIES_W'(CAPACITY);

   fcst_cmd_type         cmd;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SLOT_W-1:0]    rsp_slot_index;
   logic [ENTRIES_W-1:0] rsp_entries_now;
   logic                 rsp_overflow;
   logic                 rsp_underflow;

   // controller
   fcst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath
   fcst_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_tdata[0]),
      .req_value       (req_tdata[ITEM_W:1]),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_entries_now (rsp_entries_now)
   );

   // result beat packing
   assign rsp_tdata = {7'd0, rsp_entries_now, rsp_slot_index, rsp_status};

   // error beats on the result side
   assign rsp_overflow  = rsp_tvalid && (rsp_status == ST_OVERFLOW);
   assign rsp_underflow = rsp_tvalid && (rsp_status == ST_UNDERFLOW);

   // one request in work at a time
   `FCST_ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)
   // overflow only reported with a full table
   `FCST_ASSERT_NOW(a_overflow_full, clock, reset, rsp_overflow, rsp_entries_now == ENTRIES_FULL)
   // underflow only reported with an empty table
   `FCST_ASSERT_NOW(a_underflow_empty, clock, reset, rsp_underflow, rsp_entries_now == '0)

endmodule
